// ===== hw/rtl/stq_pkg.sv =====
package stq_pkg;

  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_CANCEL   = 2'd1;
  localparam logic [1:0] OP_DISPATCH = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  localparam logic [7:0] HANDLE_STEP = 8'd2;

  typedef struct packed {
    logic        valid;
    logic [15:0] deadline;
    logic [7:0]  tag;
    logic [7:0]  handle;
  } entry_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic        ins_commit;
    logic        rm_commit;
    logic        dispatch;
    logic [15:0] now;
    logic [15:0] ahead;
    logic [7:0]  key;
    entry_t      new_ent;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/stq_cell.sv =====
module stq_cell
  import stq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  entry_t     left,
  input  entry_t     right,
  input  logic       go_left,
  input  logic       rm_left,
  output entry_t     ent,
  output logic       go,
  output logic       rm,
  output logic       hit
);

  logic        valid;
  logic [15:0] deadline;
  logic [7:0]  tag;
  logic [7:0]  handle;
  logic [15:0] lead;

  assign lead = deadline - ctrl.now;
  // every cell from the first later entry or empty cell onward takes part in the shift
  assign go   = go_left || !valid || (lead > ctrl.ahead);
  assign hit  = valid && (handle == ctrl.key);
  assign rm   = rm_left || (valid && (ctrl.dispatch || hit));

  assign ent.valid    = valid;
  assign ent.deadline = deadline;
  assign ent.tag      = tag;
  assign ent.handle   = handle;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.ins_commit && go) begin
      valid <= go_left ? left.valid : 1'b1;
    end else if (ctrl.rm_commit && rm) begin
      valid <= right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins_commit && go) begin
      if (go_left) begin
        deadline <= left.deadline;
        tag      <= left.tag;
        handle   <= left.handle;
      end else begin
        deadline <= ctrl.new_ent.deadline;
        tag      <= ctrl.new_ent.tag;
        handle   <= ctrl.new_ent.handle;
      end
    end else if (ctrl.rm_commit && rm) begin
      deadline <= right.deadline;
      tag      <= right.tag;
      handle   <= right.handle;
    end
  end

endmodule

// ===== hw/rtl/sorted_timer_queue.sv =====
// A result is registered from the EXEC state after its transaction is taken and
// the output is free; an insert first stays in EXEC to skip each held handle.
// Transactions are handled one at a time; the handle search compares one
// candidate per cycle against all cells in parallel.
// Reset (rst, synchronous) empties the queue and restarts handles at zero;
// no clearing pass is needed.
module sorted_timer_queue
  import stq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // now[15:0], deadline[31:16], tag[39:32], cancel_handle[47:40]
  input  logic [47:0] s_tdata,
  // op[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], handle[9:2], fired_tag[17:10], trigger_update[18],
  // trigger_time[34:19], occupancy[38:35], zero[39]
  output logic [39:0] m_tdata
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {IDLE, EXEC} state_t;

  state_t      state;
  logic [1:0]  op;
  logic [15:0] now;
  logic [15:0] deadline;
  logic [7:0]  tag;
  logic [7:0]  cancel_handle;
  logic [CW-1:0] count;
  logic [7:0]  next_handle;

  logic [1:0]  status;
  logic [7:0]  handle;
  logic [7:0]  fired_tag;
  logic        trigger_update;
  logic [15:0] trigger_time;

  entry_t     chain [0:QUEUE_DEPTH+1];
  logic       go_c  [0:QUEUE_DEPTH];
  logic       rm_c  [0:QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] hit;
  cell_ctrl_t ctrl;

  logic        out_free;
  logic        full;
  logic        many;
  logic        hit_any;
  logic        commit;
  logic        searching;
  logic [1:0]  status_next;
  logic [7:0]  handle_next;
  logic [7:0]  fired_next;
  logic        upd_next;
  logic [15:0] trig_next;
  logic [CW-1:0] count_next;
  logic [CW+3:0] count_wide;

  assign chain[0]               = '0;
  assign chain[QUEUE_DEPTH + 1] = '0;
  assign go_c[0]                = 1'b0;
  assign rm_c[0]                = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    stq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .left    (chain[i]),
      .right   (chain[i + 2]),
      .go_left (go_c[i]),
      .rm_left (rm_c[i]),
      .ent     (chain[i + 1]),
      .go      (go_c[i + 1]),
      .rm      (rm_c[i + 1]),
      .hit     (hit[i])
    );
  end

  assign s_tready = (state == IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign full     = (count == CW'(QUEUE_DEPTH));
  assign many     = (count > CW'(1));
  assign hit_any  = |hit;

  // result of the held transaction, valid while in EXEC
  always_comb begin
    status_next = ST_OK;
    handle_next = '0;
    fired_next  = '0;
    upd_next    = 1'b0;
    trig_next   = '0;
    count_next  = count;
    searching   = 1'b0;
    case (op)
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (hit_any) begin
          searching = 1'b1;
        end else begin
          handle_next = next_handle;
          count_next  = count + CW'(1);
          if (go_c[1]) begin
            upd_next  = 1'b1;
            trig_next = deadline;
          end
        end
      end
      OP_CANCEL: begin
        if (!hit_any) begin
          status_next = ST_NOT_FOUND;
        end else begin
          count_next = count - CW'(1);
          if (hit[0] && many) begin
            upd_next  = 1'b1;
            trig_next = chain[2].deadline;
          end
        end
      end
      OP_DISPATCH: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          fired_next = chain[1].tag;
          count_next = count - CW'(1);
          if (many) begin
            upd_next  = 1'b1;
            trig_next = chain[2].deadline;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign commit = (state == EXEC) && !searching && out_free;

  always_comb begin
    ctrl                  = '0;
    ctrl.now              = now;
    ctrl.ahead            = deadline - now;
    ctrl.key              = (op == OP_CANCEL) ? cancel_handle : next_handle;
    ctrl.dispatch         = (op == OP_DISPATCH);
    ctrl.new_ent.valid    = 1'b1;
    ctrl.new_ent.deadline = deadline;
    ctrl.new_ent.tag      = tag;
    ctrl.new_ent.handle   = next_handle;
    ctrl.ins_commit       = commit && (op == OP_INSERT) && !full;
    ctrl.rm_commit        = commit && (((op == OP_CANCEL) && hit_any) ||
                                       ((op == OP_DISPATCH) && (count != '0)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      m_tvalid    <= 1'b0;
      count       <= '0;
      next_handle <= '0;
    end else begin
      if (m_tvalid && m_tready && !commit) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            state         <= EXEC;
            op            <= s_tuser;
            now           <= s_tdata[15:0];
            deadline      <= s_tdata[31:16];
            tag           <= s_tdata[39:32];
            cancel_handle <= s_tdata[47:40];
          end
        end
        EXEC: begin
          // skip a handle still held by a queued entry
          if (searching) begin
            next_handle <= next_handle + HANDLE_STEP;
          end else if (out_free) begin
            if (ctrl.ins_commit) begin
              next_handle <= next_handle + HANDLE_STEP;
            end
            count          <= count_next;
            status         <= status_next;
            handle         <= handle_next;
            fired_tag      <= fired_next;
            trigger_update <= upd_next;
            trigger_time   <= trig_next;
            m_tvalid       <= 1'b1;
            state          <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign count_wide = {4'b0, count};
  assign m_tdata = {1'b0, count_wide[3:0], trigger_time, trigger_update,
                    fired_tag, handle, status};

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import stq_pkg::*;

  localparam int Q_DEPTH = 8;
  localparam int RANDOM_ITEMS = 1850;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_GAP = 40;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int PH_NONE = 0;
  localparam int PH_SEND = 1;
  localparam int PH_RECV = 2;
  localparam int PH_BOTH = 3;
  localparam int PH_HOLD = 4;

  localparam int MOOD_FILL  = 0;
  localparam int MOOD_DRAIN = 1;
  localparam int MOOD_CHURN = 2;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  handle;
    logic [7:0]  fired_tag;
    logic        trig_update;
    logic [15:0] trig_time;
    logic [3:0]  occupancy;
  } reply_t;

  // Tracks the timer queue contents and the replies they imply.
  class queue_mirror;
    logic [15:0] q_deadline[Q_DEPTH];
    logic [7:0]  q_tag[Q_DEPTH];
    logic [7:0]  q_handle[Q_DEPTH];
    int          q_count;
    logic [7:0]  handle_cursor;
    reply_t      expected_replies[$];
    int          mismatches;

    function new();
      q_count = 0;
      handle_cursor = 8'd0;
      mismatches = 0;
    endfunction

    function bit handle_queued(logic [7:0] h);
      int i;
      for (i = 0; i < q_count; i++)
        if (q_handle[i] == h) return 1'b1;
      return 1'b0;
    endfunction

    function logic [7:0] queued_handle(int pos);
      return q_handle[pos];
    endfunction

    function logic [7:0] pick_cancel_target();
      if (q_count > 0 && $urandom_range(99) < 75)
        return q_handle[$urandom_range(q_count - 1)];
      return 8'($urandom_range(255));
    endfunction

    function void drop_entry(int pos, inout reply_t r);
      int i;
      q_count--;
      for (i = pos; i < q_count; i++) begin
        q_deadline[i] = q_deadline[i + 1];
        q_tag[i] = q_tag[i + 1];
        q_handle[i] = q_handle[i + 1];
      end
      // an emptied queue reports no trigger
      if (pos == 0 && q_count > 0) begin
        r.trig_update = 1'b1;
        r.trig_time = q_deadline[0];
      end
    endfunction

    function void note_request(logic [1:0] op, logic [47:0] data);
      reply_t      r;
      logic [15:0] now, dl, ahead, lead;
      logic [7:0]  tg, ch, h;
      int          pos, i, tries;
      bit          found;
      r = '0;
      now = data[15:0];
      dl = data[31:16];
      tg = data[39:32];
      ch = data[47:40];
      case (op)
        OP_INSERT: begin
          if (q_count >= Q_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            ahead = dl - now;
            pos = q_count;
            found = 1'b0;
            for (i = 0; i < q_count; i++) begin
              lead = q_deadline[i] - now;
              if (!found && lead > ahead) begin
                pos = i;
                found = 1'b1;
              end
            end
            h = handle_cursor;
            // skip handles still held by queued timers
            for (tries = 0; tries < 256; tries++) begin
              h = handle_cursor;
              handle_cursor = handle_cursor + HANDLE_STEP;
              if (!handle_queued(h)) break;
            end
            for (i = q_count; i > pos; i--) begin
              q_deadline[i] = q_deadline[i - 1];
              q_tag[i] = q_tag[i - 1];
              q_handle[i] = q_handle[i - 1];
            end
            q_deadline[pos] = dl;
            q_tag[pos] = tg;
            q_handle[pos] = h;
            q_count++;
            r.handle = h;
            if (pos == 0) begin
              r.trig_update = 1'b1;
              r.trig_time = dl;
            end
          end
        end
        OP_CANCEL: begin
          pos = -1;
          for (i = 0; i < q_count; i++)
            if (pos < 0 && q_handle[i] == ch) pos = i;
          if (pos < 0) r.status = ST_NOT_FOUND;
          else drop_entry(pos, r);
        end
        OP_DISPATCH: begin
          if (q_count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.fired_tag = q_tag[0];
            drop_entry(0, r);
          end
        end
        default: ;
      endcase
      r.occupancy = 4'(q_count);
      expected_replies.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_reply(logic [39:0] d);
      reply_t want;
      if (expected_replies.size() == 0) begin
        $error("result %0h arrived with no transaction pending", d);
        mismatches++;
        return;
      end
      want = expected_replies.pop_front();
      compare_field("status", 16'(want.status), 16'(d[1:0]));
      compare_field("handle", 16'(want.handle), 16'(d[9:2]));
      compare_field("fired_tag", 16'(want.fired_tag), 16'(d[17:10]));
      compare_field("trigger_update", 16'(want.trig_update), 16'(d[18]));
      compare_field("trigger_time", want.trig_time, d[34:19]);
      compare_field("occupancy", 16'(want.occupancy), 16'(d[38:35]));
      compare_field("zero", 16'd0, 16'(d[39]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = OP_UNUSED;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  int          phase = PH_NONE;
  bit          hold_done = 1'b0;
  int          cycle_count = 0;
  queue_mirror book = new();

  sorted_timer_queue #(
    .QUEUE_DEPTH(Q_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sorted_timer_queue test failed");
      $finish;
    end
  end

  // check the finished result before booking the new transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) book.check_reply(m_tdata);
      if (s_tvalid && s_tready) book.note_request(s_tuser, s_tdata);
    end
  end

  function automatic logic [47:0] pack_request(logic [15:0] now, logic [15:0] dl,
                                               logic [7:0] tg, logic [7:0] ch);
    return {ch, tg, dl, now};
  endfunction

  function automatic int idle_pct(bit sender);
    if (phase == PH_BOTH) return 6;
    if (sender && phase == PH_SEND) return 55;
    if (!sender && phase == PH_RECV) return 55;
    return 0;
  endfunction

  // Lands on a falling edge with the mirror up to date, idling the sender first for a random gap, which may be none.
  task automatic next_slot();
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct(1'b1)) gap++;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic push_request(logic [1:0] op, logic [47:0] data);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= data;
    do @(posedge clk); while (!s_tready);
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (phase == PH_HOLD && !hold_done) begin
        // hold off long enough for the input side to back up
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        m_tready <= !($urandom_range(99) < idle_pct(1'b0));
      end
    end
  end

  initial begin
    int          n, mood, r;
    logic [1:0]  op;
    logic [15:0] clock_now, dl;
    logic [7:0]  ch;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty queue and the unused op
    next_slot(); push_request(OP_DISPATCH, pack_request(16'h0000, 16'h0000, 8'h00, 8'h00));
    next_slot(); push_request(OP_CANCEL, pack_request(16'hFFFF, 16'hFFFF, 8'hFF, 8'h00));
    next_slot(); push_request(OP_UNUSED, pack_request(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
    // wrapped deadlines, ties placed behind, new heads
    next_slot(); push_request(OP_INSERT, pack_request(16'hFFF0, 16'h0010, 8'hFF, 8'hFF));
    next_slot(); push_request(OP_INSERT, pack_request(16'hFFF0, 16'hFFFF, 8'h00, 8'h00));
    next_slot(); push_request(OP_INSERT, pack_request(16'hFFF0, 16'hFFFF, 8'h5A, 8'hFF));
    next_slot(); push_request(OP_INSERT, pack_request(16'hFFF0, 16'h0000, 8'hA5, 8'h00));
    next_slot(); push_request(OP_INSERT, pack_request(16'hFFF0, 16'hFFF0, 8'h3C, 8'hFF));
    next_slot(); push_request(OP_INSERT, pack_request(16'h0000, 16'hFFFF, 8'h01, 8'h00));
    next_slot(); push_request(OP_INSERT, pack_request(16'h0000, 16'h0000, 8'hFE, 8'hFF));
    next_slot(); push_request(OP_INSERT, pack_request(16'h8000, 16'h7FFF, 8'h80, 8'h00));
    // full queue
    next_slot(); push_request(OP_INSERT, pack_request(16'h1234, 16'h1235, 8'h77, 8'h00));
    // odd and unknown handles, then tail, head and middle cancels
    next_slot(); push_request(OP_CANCEL, pack_request(16'h0000, 16'h0000, 8'h00, 8'h01));
    next_slot(); push_request(OP_CANCEL, pack_request(16'h0000, 16'h0000, 8'h00, 8'hFF));
    next_slot();
    push_request(OP_CANCEL, pack_request(16'h0000, 16'h0000, 8'h00, book.queued_handle(7)));
    next_slot();
    push_request(OP_CANCEL, pack_request(16'h0000, 16'h0000, 8'h00, book.queued_handle(0)));
    next_slot();
    push_request(OP_CANCEL, pack_request(16'h0000, 16'h0000, 8'h00, book.queued_handle(2)));
    // drain to empty, then once more
    repeat (6) begin
      next_slot(); push_request(OP_DISPATCH, pack_request(16'hFFFF, 16'h0000, 8'hFF, 8'hFF));
    end
    next_slot(); push_request(OP_INSERT, pack_request(16'hFFFF, 16'h0000, 8'h00, 8'hFF));

    clock_now = 16'($urandom);
    mood = MOOD_FILL;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      phase = (n * 5) / RANDOM_ITEMS;
      if (n % 64 == 0) mood = $urandom_range(2);
      next_slot();
      r = $urandom_range(99);
      case (mood)
        MOOD_FILL:  op = r < 65 ? OP_INSERT : r < 80 ? OP_CANCEL : r < 96 ? OP_DISPATCH : OP_UNUSED;
        MOOD_DRAIN: op = r < 25 ? OP_INSERT : r < 55 ? OP_CANCEL : r < 97 ? OP_DISPATCH : OP_UNUSED;
        default:    op = r < 48 ? OP_INSERT : r < 53 ? OP_CANCEL : r < 98 ? OP_DISPATCH : OP_UNUSED;
      endcase
      if ($urandom_range(99) < 90) clock_now = clock_now + 16'($urandom_range(50));
      else clock_now = 16'($urandom);
      r = $urandom_range(99);
      if (mood == MOOD_CHURN) dl = clock_now + 16'($urandom_range(15));
      else if (r < 40) dl = clock_now + 16'($urandom_range(255));
      else if (r < 60) dl = clock_now + 16'($urandom_range(3));
      else if (r < 90) dl = 16'($urandom);
      else dl = clock_now - 16'($urandom_range(1));
      ch = (op == OP_CANCEL) ? book.pick_cancel_target() : 8'($urandom);
      push_request(op, pack_request(clock_now, dl, 8'($urandom), ch));
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
    phase = PH_NONE;

    while (book.expected_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("sorted_timer_queue test passed");
    end else begin
      $display("sorted_timer_queue test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/stq_pkg.sv
hw/rtl/stq_cell.sv
hw/rtl/sorted_timer_queue.sv
test/tb_top.sv
